[src/weight_frame_change_encoder_macros.svh]
// ----------------------------------------------------------------------------
// Weight frame change encoder assertion macros
// Concurrent assertion shorthands, empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef WEIGHT_FRAME_CHANGE_ENCODER_MACROS_SVH
`define WEIGHT_FRAME_CHANGE_ENCODER_MACROS_SVH

`ifndef SYNTHESIS
`define WFCE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define WFCE_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define WFCE_ASSERT(lbl, clk, rst_n, prop, msg)
`define WFCE_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

[src/wfce_pkg.sv]
// ----------------------------------------------------------------------------
// Weight frame change encoder package
// Shared widths, constants and word types.
// ----------------------------------------------------------------------------
`default_nettype none

package wfce_pkg;

    localparam int MAX_CHANNELS_DEF = 32;
    localparam int CHAN_W           = 5;
    localparam int VALUE_W          = 8;
    localparam int WEIGHT_W         = 18;
    localparam int CFG_W            = 6;
    localparam int QUEUE_DEPTH_LOG2 = 1;

    localparam logic [CFG_W-1:0] CHANNEL_COUNT_RESET = 6'd32;

    typedef enum logic {
        KIND_SAMPLE = 1'b0,
        KIND_EOF    = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t               kind;
        logic [CHAN_W-1:0]   chan;
        logic [VALUE_W-1:0]  value;
    } cmd_t;

    typedef struct packed {
        logic                is_header;
        logic [CHAN_W-1:0]   chan;
        logic [VALUE_W-1:0]  value;
        logic                last;
    } res_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_HEAD,
        ST_PAIR
    } back_state_t;

endpackage

`default_nettype wire

[src/wfce_fifo.sv]
// ----------------------------------------------------------------------------
// Weight frame change encoder queue
// Small flop-based first-in first-out queue of fixed-width words.
// ----------------------------------------------------------------------------
`default_nettype none

module wfce_fifo #(
    parameter int WIDTH      = 14,
    parameter int DEPTH_LOG2 = 1
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_push,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  wr_full,
    input  wire logic             rd_pop,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  rd_empty
);

    localparam int DEPTH = 1 << DEPTH_LOG2;

    logic [WIDTH-1:0]      mem_reg [DEPTH];
    logic [DEPTH_LOG2-1:0] wptr_reg;
    logic [DEPTH_LOG2-1:0] rptr_reg;
    logic [DEPTH_LOG2:0]   cnt_reg;
    logic [DEPTH_LOG2:0]   cnt_next;
    logic                  do_push;
    logic                  do_pop;

    assign wr_full  = (cnt_reg == (DEPTH_LOG2+1)'(DEPTH));
    assign rd_empty = (cnt_reg == '0);
    assign do_push  = wr_push && !wr_full;
    assign do_pop   = rd_pop && !rd_empty;
    assign rd_data  = mem_reg[rptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

[src/wfce_front.sv]
// ----------------------------------------------------------------------------
// Weight frame change encoder front end
// Holds the channel count, quantizes samples and drops out-of-range channels.
// ----------------------------------------------------------------------------
`default_nettype none

module wfce_front
    import wfce_pkg::*;
#(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [CFG_W-1:0]           cfg_wdata,
    input  wire logic                       push,
    input  wire logic                       kind,
    input  wire logic [CHAN_W-1:0]          channel,
    input  wire logic signed [WEIGHT_W-1:0] weight,
    input  wire logic                       q_full,
    output logic                            q_push,
    output cmd_t                            q_data
);

    localparam int TW = WEIGHT_W + 9;

    logic [CFG_W-1:0]     channel_count_reg;
    logic signed [TW-1:0] w_ext;
    logic signed [TW-1:0] t_val;
    logic [VALUE_W-1:0]   q_val;
    logic                 in_range;
    kind_t                kind_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_count_reg <= CHANNEL_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            channel_count_reg <= cfg_wdata;
        end
    end

    // w*255 + 0.5 in Q.16, then floor by dropping the fraction
    always_comb
    begin
        w_ext = TW'(weight);
        t_val = (w_ext <<< 8) - w_ext + TW'(32768);
        if (t_val[TW-1])
        begin
            q_val = '0;
        end
        else if (|t_val[TW-2:VALUE_W+16])
        begin
            q_val = '1;
        end
        else
        begin
            q_val = t_val[VALUE_W+15:16];
        end
    end

    assign kind_in  = kind_t'(kind);
    assign in_range = ({1'b0, channel} < channel_count_reg)
                   && (7'(channel) < 7'(MAX_CHANNELS));

    // drop ignored samples here so they never reach the back end
    assign q_push       = push && !q_full && ((kind_in == KIND_EOF) || in_range);
    assign q_data.kind  = kind_in;
    assign q_data.chan  = channel;
    assign q_data.value = q_val;

endmodule

`default_nettype wire

[src/wfce_back.sv]
// ----------------------------------------------------------------------------
// Weight frame change encoder back end
// Keeps channel history and the pair buffer, and drains frames as words.
// ----------------------------------------------------------------------------
`default_nettype none

`include "weight_frame_change_encoder_macros.svh"

module wfce_back
    import wfce_pkg::*;
#(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cmd_empty,
    input  wire cmd_t cmd_data,
    output logic      cmd_pop,
    input  wire logic res_full,
    output logic      res_push,
    output res_t      res_data
);

    localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CW = $clog2(MAX_CHANNELS + 1);
    localparam logic [CW-1:0] CountMax = CW'(MAX_CHANNELS);

    back_state_t state_reg;
    back_state_t state_next;
    cmd_t        cmd_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [AW-1:0] idx_reg;
    logic [AW-1:0] idx_next;

    // history word: older value in the upper byte, newer in the lower
    logic [2*VALUE_W-1:0]        hist_mem [MAX_CHANNELS];
    logic [MAX_CHANNELS-1:0]     hist_valid_reg;
    logic [2*VALUE_W-1:0]        hist_rdata_reg;
    logic                        hist_rvalid_reg;
    logic                        hist_rd_en;
    logic                        hist_wr_en;
    logic [AW-1:0]               hist_rd_addr;
    logic [AW-1:0]               hist_wr_addr;
    logic [2*VALUE_W-1:0]        hist_wdata;

    logic [CHAN_W+VALUE_W-1:0]   pbuf_mem [MAX_CHANNELS];
    logic [CHAN_W+VALUE_W-1:0]   pbuf_rdata_reg;
    logic                        pbuf_rd_en;
    logic [AW-1:0]               pbuf_rd_addr;
    logic                        pbuf_wr_en;
    logic [AW-1:0]               pbuf_wr_addr;

    logic [VALUE_W-1:0]          prev_q;
    logic [VALUE_W-1:0]          cur_q;
    logic                        changed;
    logic                        pair_last;

    assign hist_rd_addr = AW'(cmd_data.chan);
    assign hist_wr_addr = AW'(cmd_reg.chan);
    assign pbuf_wr_addr = count_reg[AW-1:0];

    assign prev_q    = hist_rvalid_reg ? hist_rdata_reg[2*VALUE_W-1:VALUE_W] : '0;
    assign cur_q     = hist_rvalid_reg ? hist_rdata_reg[VALUE_W-1:0] : '0;
    assign changed   = (prev_q != cmd_reg.value) || (cur_q != cmd_reg.value);
    assign pair_last = ((CW'(idx_reg) + CW'(1)) == count_reg);

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        cmd_pop      = 1'b0;
        res_push     = 1'b0;
        res_data     = '0;
        hist_rd_en   = 1'b0;
        hist_wr_en   = 1'b0;
        hist_wdata   = {cur_q, cmd_reg.value};
        pbuf_rd_en   = 1'b0;
        pbuf_rd_addr = '0;
        pbuf_wr_en   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop = 1'b1;
                    if (cmd_data.kind == KIND_EOF)
                    begin
                        state_next = ST_HEAD;
                    end
                    else
                    begin
                        hist_rd_en = 1'b1;
                        state_next = ST_CMP;
                    end
                end
            end
            ST_CMP:
            begin
                if (changed)
                begin
                    hist_wr_en = 1'b1;
                    // saturate: history still shifts, pair is dropped
                    if (count_reg < CountMax)
                    begin
                        pbuf_wr_en = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                state_next = ST_IDLE;
            end
            ST_HEAD:
            begin
                res_data.is_header = 1'b1;
                res_data.value     = VALUE_W'(count_reg);
                res_data.last      = (count_reg == '0);
                if (!res_full)
                begin
                    res_push = 1'b1;
                    if (count_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        pbuf_rd_en = 1'b1;
                        idx_next   = '0;
                        state_next = ST_PAIR;
                    end
                end
            end
            ST_PAIR:
            begin
                res_data.chan  = pbuf_rdata_reg[CHAN_W+VALUE_W-1:VALUE_W];
                res_data.value = pbuf_rdata_reg[VALUE_W-1:0];
                res_data.last  = pair_last;
                if (!res_full)
                begin
                    res_push = 1'b1;
                    if (pair_last)
                    begin
                        count_next = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next     = idx_reg + 1'b1;
                        pbuf_rd_en   = 1'b1;
                        pbuf_rd_addr = idx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            idx_reg        <= '0;
            hist_valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            if (hist_wr_en)
            begin
                hist_valid_reg[hist_wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            cmd_reg <= cmd_data;
        end
        if (hist_rd_en)
        begin
            hist_rdata_reg  <= hist_mem[hist_rd_addr];
            hist_rvalid_reg <= hist_valid_reg[hist_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (hist_wr_en)
        begin
            hist_mem[hist_wr_addr] <= hist_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pbuf_rd_en)
        begin
            pbuf_rdata_reg <= pbuf_mem[pbuf_rd_addr];
        end
        if (pbuf_wr_en)
        begin
            pbuf_mem[pbuf_wr_addr] <= {cmd_reg.chan, cmd_reg.value};
        end
    end

    `WFCE_ASSERT(a_count_bound, clk, rst_n, count_reg <= CountMax, "pair count above depth")
    `WFCE_ASSERT(a_cmp_after_idle, clk, rst_n, (state_reg == ST_CMP) |-> ($past(state_reg) == ST_IDLE), "compare without read")
    `WFCE_ASSERT(a_last_clears, clk, rst_n, (res_push && res_data.last) |=> ((count_reg == '0) && (state_reg == ST_IDLE)), "frame end did not clear")
    `WFCE_ASSERT_NEVER(a_push_full, clk, rst_n, res_push && res_full, "result word pushed into full queue")

endmodule

`default_nettype wire

[src/weight_frame_change_encoder.sv]
// ----------------------------------------------------------------------------
// Weight frame change encoder
// Turns per-channel weight samples into framed (channel, value) change words.
// ----------------------------------------------------------------------------
// Samples enter through a two-word command queue; out-of-range samples are
// dropped there and cost nothing further. The back end handles each kept
// sample as a history memory read, then a compare and write, and each end
// of frame with N buffered pairs as a header, then one pair a cycle from
// the pair buffer read port, holding whenever the result queue is full.
// Results wait in a two-word queue, so the input side keeps taking words
// while the consumer stalls, until a draining frame backs up into the
// command queue. No clearing pass follows reset.
`default_nettype none

module weight_frame_change_encoder
    import wfce_pkg::*;
#(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [CFG_W-1:0]           cfg_wdata,
    input  wire logic                       push,
    output logic                            full,
    input  wire logic                       kind,
    input  wire logic [CHAN_W-1:0]          channel,
    input  wire logic signed [WEIGHT_W-1:0] weight,
    output logic                            empty,
    input  wire logic                       pop,
    output logic                            is_header,
    output logic [CHAN_W-1:0]               chan_out,
    output logic [VALUE_W-1:0]              value_out,
    output logic                            last
);

    logic cmd_push;
    cmd_t cmd_wdata;
    logic cmd_full;
    logic cmd_pop;
    cmd_t cmd_rdata;
    logic cmd_empty;
    logic res_push;
    res_t res_wdata;
    logic res_full;
    res_t res_rdata;

    assign full = cmd_full;

    wfce_front #(
        .MAX_CHANNELS(MAX_CHANNELS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .push     (push),
        .kind     (kind),
        .channel  (channel),
        .weight   (weight),
        .q_full   (cmd_full),
        .q_push   (cmd_push),
        .q_data   (cmd_wdata)
    );

    wfce_fifo #(
        .WIDTH     ($bits(cmd_t)),
        .DEPTH_LOG2(QUEUE_DEPTH_LOG2)
    ) u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_push (cmd_push),
        .wr_data (cmd_wdata),
        .wr_full (cmd_full),
        .rd_pop  (cmd_pop),
        .rd_data (cmd_rdata),
        .rd_empty(cmd_empty)
    );

    wfce_back #(
        .MAX_CHANNELS(MAX_CHANNELS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_empty(cmd_empty),
        .cmd_data (cmd_rdata),
        .cmd_pop  (cmd_pop),
        .res_full (res_full),
        .res_push (res_push),
        .res_data (res_wdata)
    );

    wfce_fifo #(
        .WIDTH     ($bits(res_t)),
        .DEPTH_LOG2(QUEUE_DEPTH_LOG2)
    ) u_res_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_push (res_push),
        .wr_data (res_wdata),
        .wr_full (res_full),
        .rd_pop  (pop),
        .rd_data (res_rdata),
        .rd_empty(empty)
    );

    assign is_header = res_rdata.is_header;
    assign chan_out  = res_rdata.chan;
    assign value_out = res_rdata.value;
    assign last      = res_rdata.last;

endmodule

`default_nettype wire
